[src/clpws_pkg.sv]
// ----------------------------------------------------------------------------
// clpws_pkg - shared types and constants for the character LCD write sequencer
// Payload structs, job codes, register indexes and bus helper functions.
// ----------------------------------------------------------------------------
package clpws_pkg;

  localparam int WAIT_W      = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  // input op codes
  localparam logic [1:0] OP_DATA = 2'd0;
  localparam logic [1:0] OP_CMD  = 2'd1;
  localparam logic [1:0] OP_INIT = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DATA_SETUP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_PULSE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POWERUP      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT       = 3'd4;

  // register reset values
  localparam logic [WAIT_W-1:0] RST_DATA_SETUP   = 24'd1000000;
  localparam logic [WAIT_W-1:0] RST_ENABLE_PULSE = 24'd10000;
  localparam logic [WAIT_W-1:0] RST_SETTLE       = 24'd100000;
  localparam logic [WAIT_W-1:0] RST_POWERUP      = 24'd10000000;
  localparam logic              RST_INVERT       = 1'b1;

  localparam logic [WAIT_W-1:0] WAIT_MAX = {WAIT_W{1'b1}};

  // init command bytes
  localparam logic [7:0] CMD_WAKE     = 8'h30;
  localparam logic [7:0] CMD_FUNC_SET = 8'h38;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_DISP_BLK = 8'h0F;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] CMD_HOME     = 8'h80;

  // slot of the init command that carries the power-up wait, and the final slot
  localparam logic [2:0] INIT_SLOT_POWERUP = 3'd6;
  localparam logic [2:0] INIT_SLOT_LAST    = 3'd7;

  typedef enum logic [1:0] {
    JOB_DATA = 2'd0,
    JOB_CMD  = 2'd1,
    JOB_INIT = 2'd2
  } job_kind_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] byte_value;
    logic       cursor_blink;
  } in_item_t;

  typedef struct packed {
    logic              rs_level;
    logic              rw_level;
    logic              enable_level;
    logic [7:0]        data_pins;
    logic [WAIT_W-1:0] wait_cycles;
    logic              last;
  } out_item_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] byte_value;
    logic       blink;
  } job_t;

  typedef struct packed {
    logic [WAIT_W-1:0] data_setup_wait;
    logic [WAIT_W-1:0] enable_pulse_wait;
    logic [WAIT_W-1:0] settle_wait;
    logic [WAIT_W-1:0] powerup_wait;
    logic              invert_outputs;
  } cfg_t;

  function automatic logic [7:0] reverse8(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = b[k];
    end
    return r;
  endfunction

  function automatic logic [7:0] init_cmd(input logic [2:0] slot, input logic blink);
    logic [7:0] c;
    case (slot)
      3'd0, 3'd1, 3'd2: c = CMD_WAKE;
      3'd3:             c = CMD_FUNC_SET;
      3'd4:             c = blink ? CMD_DISP_BLK : CMD_DISP_ON;
      3'd5:             c = CMD_CLEAR;
      3'd6:             c = CMD_ENTRY;
      3'd7:             c = CMD_HOME;
      default:          c = CMD_HOME;
    endcase
    return c;
  endfunction

endpackage

[src/clpws_front.sv]
// ----------------------------------------------------------------------------
// clpws_front - input decode
// Classifies each input beat into a job and drops the unused op code.
// ----------------------------------------------------------------------------
module clpws_front (
  input  logic               in_valid,
  input  clpws_pkg::in_item_t in_data,
  input  logic               q_full,
  output logic               in_stall,
  output logic               push,
  output clpws_pkg::job_t    push_job
);

  logic op_ok;

  assign in_stall = q_full;

  always_comb begin
    op_ok           = 1'b1;
    push_job.kind   = clpws_pkg::JOB_DATA;
    case (in_data.op)
      clpws_pkg::OP_DATA: push_job.kind = clpws_pkg::JOB_DATA;
      clpws_pkg::OP_CMD:  push_job.kind = clpws_pkg::JOB_CMD;
      clpws_pkg::OP_INIT: push_job.kind = clpws_pkg::JOB_INIT;
      default:            op_ok = 1'b0;  // unused op: accepted, no results
    endcase
    push_job.byte_value = in_data.byte_value;
    push_job.blink      = in_data.cursor_blink;
  end

  assign push = in_valid & ~in_stall & op_ok;

endmodule

[src/clpws_queue.sv]
// ----------------------------------------------------------------------------
// clpws_queue - short job queue
// Register FIFO between decode and the pin sequencer.
// ----------------------------------------------------------------------------
module clpws_queue #(
  parameter int DEPTH = clpws_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  clpws_pkg::job_t push_job,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output clpws_pkg::job_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  clpws_pkg::job_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_FULL);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

[src/clpws_back.sv]
// ----------------------------------------------------------------------------
// clpws_back - pin sequencer
// Steps through the pin snapshots of one job, one beat per cycle while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module clpws_back (
  input  logic                clk,
  input  logic                rst_n,
  input  clpws_pkg::cfg_t     cfg,
  input  logic                q_empty,
  input  clpws_pkg::job_t     q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output clpws_pkg::out_item_t out_data
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PRE_RW = 6'b000010,
    ST_PRE_E  = 6'b000100,
    ST_SETUP  = 6'b001000,
    ST_HIGH   = 6'b010000,
    ST_LOW    = 6'b100000
  } st_t;

  st_t             st_r, st_nxt;
  clpws_pkg::job_t job_r, job_nxt;
  logic [2:0]      slot_r, slot_nxt;
  logic            rs_r, rs_nxt;      // logical RS level, persists across jobs
  logic [7:0]      bus_r, bus_nxt;    // logical data pins, persists across jobs
  logic            out_valid_r, out_valid_nxt;
  clpws_pkg::out_item_t out_r, out_nxt;

  logic            is_init;
  logic            advance;
  logic            emit;
  logic            beat_last;
  logic            beat_e;
  logic            beat_rs;
  logic [7:0]      beat_bus;
  logic [7:0]      cur_byte;
  logic [clpws_pkg::WAIT_W-1:0] beat_wait;
  logic [clpws_pkg::WAIT_W:0]   wait_sum;

  assign is_init   = (job_r.kind == clpws_pkg::JOB_INIT);
  assign advance   = ~out_valid_r | ~out_stall;
  assign emit      = advance & (st_r != ST_IDLE);
  assign beat_last = (st_r == ST_LOW) & (~is_init | (slot_r == clpws_pkg::INIT_SLOT_LAST));
  assign pop       = ~q_empty & ((st_r == ST_IDLE) | (emit & beat_last));
  assign cur_byte  = is_init ? clpws_pkg::init_cmd(slot_r, job_r.blink) : job_r.byte_value;
  assign wait_sum  = {1'b0, cfg.settle_wait} + {1'b0, cfg.powerup_wait};

  always_comb begin
    beat_rs   = rs_r;
    beat_bus  = bus_r;
    beat_e    = 1'b0;
    beat_wait = '0;
    case (st_r)
      ST_PRE_RW, ST_PRE_E: beat_wait = '0;
      ST_SETUP: begin
        beat_rs   = (job_r.kind == clpws_pkg::JOB_DATA);
        beat_bus  = clpws_pkg::reverse8(cur_byte);
        beat_wait = beat_rs ? cfg.data_setup_wait : '0;
      end
      ST_HIGH: begin
        beat_e    = 1'b1;
        beat_wait = cfg.enable_pulse_wait;
      end
      ST_LOW: begin
        if (is_init && slot_r == clpws_pkg::INIT_SLOT_POWERUP) begin
          // entry-mode command carries the power-up hold, saturating
          beat_wait = wait_sum[clpws_pkg::WAIT_W] ? clpws_pkg::WAIT_MAX
                                                  : wait_sum[clpws_pkg::WAIT_W-1:0];
        end else begin
          beat_wait = cfg.settle_wait;
        end
      end
      default: beat_wait = '0;
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    job_nxt       = job_r;
    slot_nxt      = slot_r;
    rs_nxt        = rs_r;
    bus_nxt       = bus_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (advance) begin
      out_valid_nxt = emit;
    end

    if (emit) begin
      rs_nxt                = beat_rs;
      bus_nxt               = beat_bus;
      out_nxt.rs_level      = beat_rs ^ cfg.invert_outputs;
      out_nxt.rw_level      = cfg.invert_outputs;
      out_nxt.enable_level  = beat_e ^ cfg.invert_outputs;
      out_nxt.data_pins     = beat_bus ^ {8{cfg.invert_outputs}};
      out_nxt.wait_cycles   = beat_wait;
      out_nxt.last          = beat_last;
      case (st_r)
        ST_PRE_RW: st_nxt = ST_PRE_E;
        ST_PRE_E:  st_nxt = ST_SETUP;
        ST_SETUP:  st_nxt = ST_HIGH;
        ST_HIGH:   st_nxt = ST_LOW;
        ST_LOW: begin
          st_nxt   = beat_last ? ST_IDLE : ST_SETUP;
          slot_nxt = slot_r + 1'b1;
        end
        default:   st_nxt = ST_IDLE;
      endcase
    end

    if (pop) begin
      job_nxt  = q_head;
      slot_nxt = '0;
      st_nxt   = (q_head.kind == clpws_pkg::JOB_INIT) ? ST_PRE_RW : ST_SETUP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      slot_r      <= '0;
      rs_r        <= 1'b0;
      bus_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      slot_r      <= slot_nxt;
      rs_r        <= rs_nxt;
      bus_r       <= bus_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/char_lcd_parallel_write_sequencer_top.sv]
// ----------------------------------------------------------------------------
// char_lcd_parallel_write_sequencer_top - character LCD 8-bit bus sequencer
// Turns data/command/init requests into timed snapshots of the LCD pins.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one beat per request (data write, command write, initialise).
//            in_stall rises only when the job queue is full.
//   out_*  : one beat per pin snapshot, with the cycles to hold it; last
//            marks the final snapshot of a request.
//   cfg_*  : register writes, always taken (cfg_ready is tied high); write
//            only while the block is idle.
// Path: a request is queued, then popped, then its first snapshot registered.
// Throughput: one snapshot per cycle unless the output stalls. A write
//   is the setup, enable-high and enable-low snapshots; an init is two
//   lead snapshots, then those three for each of its eight commands.
//   Jobs run back to back with no gap while the queue holds the next one.
// Reset: queue empty, output empty, logical pin levels low, registers at
//   their documented defaults.
// Receiver stall: the output register holds its beat; the sequencer pauses,
//   the queue fills, then in_stall rises. Nothing is dropped.
// ----------------------------------------------------------------------------
module char_lcd_parallel_write_sequencer_top #(
  parameter int QUEUE_DEPTH = clpws_pkg::QUEUE_DEPTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  clpws_pkg::in_item_t                   in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output clpws_pkg::out_item_t                  out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [clpws_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [clpws_pkg::WAIT_W-1:0]          cfg_data
);

  clpws_pkg::cfg_t cfg_r, cfg_nxt;
  clpws_pkg::job_t push_job;
  clpws_pkg::job_t q_head;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  assign cfg_ready = 1'b1;

  // register file, written beat by beat; unknown indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        clpws_pkg::REG_DATA_SETUP:   cfg_nxt.data_setup_wait   = cfg_data;
        clpws_pkg::REG_ENABLE_PULSE: cfg_nxt.enable_pulse_wait = cfg_data;
        clpws_pkg::REG_SETTLE:       cfg_nxt.settle_wait       = cfg_data;
        clpws_pkg::REG_POWERUP:      cfg_nxt.powerup_wait      = cfg_data;
        clpws_pkg::REG_INVERT:       cfg_nxt.invert_outputs    = cfg_data[0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_setup_wait   <= clpws_pkg::RST_DATA_SETUP;
      cfg_r.enable_pulse_wait <= clpws_pkg::RST_ENABLE_PULSE;
      cfg_r.settle_wait       <= clpws_pkg::RST_SETTLE;
      cfg_r.powerup_wait      <= clpws_pkg::RST_POWERUP;
      cfg_r.invert_outputs    <= clpws_pkg::RST_INVERT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: decode and push
  clpws_front u_front (
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .push_job (push_job)
  );

  // queue between decode and sequencer
  clpws_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  // back: pin snapshot sequencer with output register
  clpws_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
